// ===== hdl/crs_pkg.sv =====
// Shared constants, event codes and register indexes of the clip rectangle stack.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package crs_pkg;

  // Defaults for the top-level parameters.
  localparam int STACK_DEPTH_DEF = 64;
  localparam int COORD_BITS_DEF  = 16;

  // Fixed field widths.
  localparam int CANVAS_BITS   = 15;
  localparam int INV_BITS      = 16;
  localparam int CFG_IDX_BITS  = 8;
  localparam int EVENT_BITS    = 3;
  localparam int OUT_USER_BITS = EVENT_BITS + 2;

  localparam logic [INV_BITS-1:0] INVALID_MAX = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_CANVAS_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CANVAS_HEIGHT = 8'd1;

  // Operation carried in the input tuser.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [EVENT_BITS-1:0] {
    EV_PUSHED          = 3'd0,
    EV_PUSH_INVALID    = 3'd1,
    EV_PUSH_WHILE_INV  = 3'd2,
    EV_POPPED          = 3'd3,
    EV_POP_VALID       = 3'd4,
    EV_POP_STILL_INV   = 3'd5,
    EV_POP_EMPTY       = 3'd6,
    EV_PUSH_FULL       = 3'd7
  } event_e;

endpackage

`default_nettype wire

// ===== hdl/crs_out_buf.sv =====
// Two-entry output buffer (output register plus skid register) for result items.
// Generic payload width; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module crs_out_buf #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [WIDTH-1:0] in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic      [WIDTH-1:0] out_data_o
);

  logic             main_v_q, skid_v_q;
  logic [WIDTH-1:0] main_q, skid_q;
  logic             in_fire, out_free;

  // Accept while the skid slot is free, so a stalled result never blocks one more item.
  assign in_ready_o = !skid_v_q;
  assign in_fire    = in_valid_i && !skid_v_q;
  assign out_free   = !main_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        main_v_q <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        main_v_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_v_q) begin
        main_q <= skid_q;
      end else if (in_fire) begin
        main_q <= in_data_i;
      end
    end else if (in_fire) begin
      skid_q <= in_data_i;
    end
  end

  assign out_valid_o = main_v_q;
  assign out_data_o  = main_q;

endmodule

`default_nettype wire

// ===== hdl/clip_rectangle_stack.sv =====
// Top level of the nested clip rectangle stack: stack control, entry memory, output buffer.
// Depends on crs_pkg and crs_out_buf.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// Each input item is a push (tuser bit 0 low) of a requested rectangle in tdata, or a pop
// (tuser bit 0 high, tdata ignored). A push intersects the request with the current clip,
// which is the canvas when nothing is stacked. Every item yields exactly one result item:
// an event code and two status flags in tuser, and the current clip after the operation
// in tdata. While the clip is invalid the result clip reads as (-1,-1,0,0).
// The canvas size is set through the configuration channel, which is always ready; write
// it only while no item is in flight.
// The result is registered in the output buffer, and one item is accepted every cycle
// while the receiver takes results. The top stacked rectangle lives in a register; the
// entry just below it is prefetched from the stack memory, so a pop right after a pop still
// finds its next top ready. The rate is set by that single registered memory read port.
// If the receiver stalls, one more item is accepted into the skid register, after which
// s_axis_tready_o falls until the receiver takes a result. Nothing is lost or repeated.
// Reset clears the stack count, the invalid depth, the canvas size and the output valid
// flags. Stack memory entries are not cleared; stale prefetched values are never used.

module clip_rectangle_stack #(
  parameter int STACK_DEPTH = crs_pkg::STACK_DEPTH_DEF,
  parameter int COORD_BITS  = crs_pkg::COORD_BITS_DEF,
  localparam int DATA_W     = ((4 * COORD_BITS + 7) / 8) * 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration write channel.
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [crs_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire logic [crs_pkg::CANVAS_BITS-1:0]  cfg_data_i,
  // Input items.
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata from bit 0 up: req_left, req_top, req_right, req_bottom, zero padding.
  input  wire logic [DATA_W-1:0]            s_axis_tdata_i,
  // tuser from bit 0 up: operation.
  input  wire logic                         s_axis_tuser_i,
  // Result items.
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  // tdata from bit 0 up: clip_left, clip_top, clip_right, clip_bottom, zero padding.
  output logic      [DATA_W-1:0]            m_axis_tdata_o,
  // tuser from bit 0 up: event_kind (3 bits), stack_nonempty, clip_invalid.
  output logic      [crs_pkg::OUT_USER_BITS-1:0] m_axis_tuser_o
);

  import crs_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int RECT_W = 4 * C;
  localparam int AW     = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  // Compare width wide enough for both signed coordinates and the unsigned canvas size.
  localparam int CMP_W  = ((C > CANVAS_BITS + 1) ? C : CANVAS_BITS + 1) + 1;
  localparam int RES_W  = OUT_USER_BITS + RECT_W;

  // Configuration.
  logic [CANVAS_BITS-1:0] canvas_w_q, canvas_h_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_w_q <= '0;
      canvas_h_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_CANVAS_WIDTH) begin
        canvas_w_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_CANVAS_HEIGHT) begin
        canvas_h_q <= cfg_data_i;
      end
    end
  end

  // Stack state.
  logic [CNT_W-1:0]    count_q, count_d;
  logic [INV_BITS-1:0] inv_q, inv_d;
  logic [RECT_W-1:0]   top_q, top_d;
  logic [RECT_W-1:0]   below_q;
  logic [RECT_W-1:0]   mem_q [STACK_DEPTH];
  logic                push_we;
  logic [AW-1:0]       rd_addr;

  logic in_fire, buf_ready;
  assign s_axis_tready_o = buf_ready;
  assign in_fire         = s_axis_tvalid_i && buf_ready;

  // Requested rectangle and current clip, widened for comparison.
  logic signed [C-1:0]     req_l, req_t, req_r, req_b;
  logic signed [C-1:0]     top_l, top_t, top_r, top_b;
  logic signed [CMP_W-1:0] cur_l, cur_t, cur_r, cur_b;
  logic signed [CMP_W-1:0] is_l, is_t, is_r, is_b;
  logic                    is_nonempty;

  assign req_l = s_axis_tdata_i[C-1:0];
  assign req_t = s_axis_tdata_i[2*C-1:C];
  assign req_r = s_axis_tdata_i[3*C-1:2*C];
  assign req_b = s_axis_tdata_i[4*C-1:3*C];
  assign top_l = top_q[C-1:0];
  assign top_t = top_q[2*C-1:C];
  assign top_r = top_q[3*C-1:2*C];
  assign top_b = top_q[4*C-1:3*C];

  always_comb begin
    if (count_q == '0) begin
      cur_l = '0;
      cur_t = '0;
      cur_r = CMP_W'(canvas_w_q);
      cur_b = CMP_W'(canvas_h_q);
    end else begin
      cur_l = CMP_W'(top_l);
      cur_t = CMP_W'(top_t);
      cur_r = CMP_W'(top_r);
      cur_b = CMP_W'(top_b);
    end
    is_l = (CMP_W'(req_l) > cur_l) ? CMP_W'(req_l) : cur_l;
    is_t = (CMP_W'(req_t) > cur_t) ? CMP_W'(req_t) : cur_t;
    is_r = (CMP_W'(req_r) < cur_r) ? CMP_W'(req_r) : cur_r;
    is_b = (CMP_W'(req_b) < cur_b) ? CMP_W'(req_b) : cur_b;
    is_nonempty = (is_l < is_r) && (is_t < is_b);
  end

  // Next state and event for the accepted item.
  event_e ev;

  always_comb begin
    count_d = count_q;
    inv_d   = inv_q;
    top_d   = top_q;
    push_we = 1'b0;
    ev      = EV_POP_EMPTY;
    if (in_fire) begin
      if (s_axis_tuser_i == OP_PUSH) begin
        if (inv_q != '0) begin
          if (inv_q != INVALID_MAX) begin
            inv_d = inv_q + INV_BITS'(1);
          end
          ev = EV_PUSH_WHILE_INV;
        end else if (is_nonempty) begin
          if (count_q == CNT_W'(STACK_DEPTH)) begin
            ev = EV_PUSH_FULL;
          end else begin
            push_we = 1'b1;
            top_d   = {is_b[C-1:0], is_r[C-1:0], is_t[C-1:0], is_l[C-1:0]};
            count_d = count_q + CNT_W'(1);
            ev      = EV_PUSHED;
          end
        end else begin
          inv_d = INV_BITS'(1);
          ev    = EV_PUSH_INVALID;
        end
      end else begin
        if (inv_q != '0) begin
          inv_d = inv_q - INV_BITS'(1);
          ev    = (inv_d == '0) ? EV_POP_VALID : EV_POP_STILL_INV;
        end else if (count_q != '0) begin
          count_d = count_q - CNT_W'(1);
          top_d   = below_q;
          ev      = EV_POPPED;
        end else begin
          ev = EV_POP_EMPTY;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      inv_q   <= '0;
    end else begin
      count_q <= count_d;
      inv_q   <= inv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
  end

  // Every stacked entry is written to memory; the entry below the next top is prefetched.
  // The write goes to the old count, never the address read in the same cycle.
  logic [CNT_W-1:0] rd_full;
  assign rd_full = count_d - CNT_W'(2);
  assign rd_addr = rd_full[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (push_we) begin
      mem_q[count_q[AW-1:0]] <= top_d;
    end
    below_q <= mem_q[rd_addr];
  end

  // Result item.
  logic [RECT_W-1:0] clip_word;
  logic              res_nonempty, res_invalid;
  logic [RES_W-1:0]  res_in, res_out;

  always_comb begin
    if (inv_d != '0) begin
      clip_word = {{C{1'b0}}, {C{1'b0}}, {C{1'b1}}, {C{1'b1}}};
    end else if (count_d == '0) begin
      clip_word = {C'(canvas_h_q), C'(canvas_w_q), {C{1'b0}}, {C{1'b0}}};
    end else begin
      clip_word = top_d;
    end
  end

  assign res_nonempty = (count_d != '0);
  assign res_invalid  = (inv_d != '0);
  assign res_in       = {clip_word, res_invalid, res_nonempty, ev};

  crs_out_buf #(
    .WIDTH(RES_W)
  ) u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (buf_ready),
    .in_data_i  (res_in),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_o (res_out)
  );

  assign m_axis_tuser_o = res_out[OUT_USER_BITS-1:0];
  assign m_axis_tdata_o = DATA_W'(res_out[RES_W-1:OUT_USER_BITS]);

  // Checks.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(STACK_DEPTH))
    else $error("stack count exceeds depth");

  a_pop_lowers_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tuser_i == OP_POP && inv_q == '0 && count_q != '0)
      |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("pop of a stacked entry did not lower the count");

  a_invalid_keeps_stack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inv_q != '0) |=> count_q == $past(count_q))
    else $error("stack changed while the clip was invalid");

  a_idle_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> (count_q == $past(count_q)) && (inv_q == $past(inv_q)))
    else $error("state changed without an accepted item");

endmodule

`default_nettype wire
